/* src/assert_macros.svh */
// Assertion helpers included by the core RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge out of reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/kmdeq_pkg.sv */
package kmdeq_pkg;

    localparam int LEVEL_BITS = 18;
    localparam int KNUM_W     = 7;

    localparam logic [7:0] COUNT_MAX      = 8'hFF;
    localparam logic [7:0] DEBOUNCE_RESET = 8'd5;

    localparam logic [1:0] ACT_SCAN          = 2'd0;
    localparam logic [1:0] ACT_DRAIN_PRESS   = 2'd1;
    localparam logic [1:0] ACT_DRAIN_RELEASE = 2'd2;

    localparam logic REG_DEBOUNCE = 1'b0;

    typedef struct packed {
        logic [1:0]  action;
        logic [17:0] key_levels;
    } req_t;

    typedef struct packed {
        logic [5:0] key_index;
        logic [4:0] event_count;
        logic       queue_empty;
        logic       last;
        logic [4:0] presses_pending;
        logic [4:0] releases_pending;
    } evt_t;

endpackage

/* src/key_matrix_debounce_event_queue_core.sv */
// Key matrix scanner with per-key debounce and press/release event queues.
// Request channel (req_valid, req_stall, req): a scan word carries one sample of
// the whole matrix, row-major; a drain word empties the press or release queue.
// Event channel (evt_valid, evt_stall, evt): one word per drained entry, oldest
// first, with last set on the final one; an empty queue gives a single word
// with queue_empty set. A scan gives no event words.
// The hold counters sit in a memory with one read and one write port that one
// increment-and-compare unit visits one key per cycle during a scan, reading
// the next key while writing back the current one.
// A drain passes through ST_DRAIN_RD and then ST_DRAIN_OUT for each entry, as the
// queue memory's read port is registered; an empty queue goes to ST_DRAIN_EMPTY.
// The block takes the next request while the last event word still waits.
// When the receiver stalls, the event word holds and the drain waits with it.
// Reset clears all counters, down flags and queue fills and sets the debounce
// count to 5; it takes effect at once, with no clearing pass.
// The debounce count sits at APB byte address 0.
module key_matrix_debounce_event_queue_core
    import kmdeq_pkg::*;
#(
    parameter int ROWS        = 3,
    parameter int COLS        = 6,
    parameter int QUEUE_DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        req_valid,
    output logic        req_stall,
    input  req_t        req,

    output logic        evt_valid,
    input  logic        evt_stall,
    output evt_t        evt,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int NUM_KEYS = ROWS * COLS;
    localparam int KEY_W    = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int KCNT_W   = $clog2(NUM_KEYS + 1);
    localparam int QA_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W   = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN_RD,
        ST_DRAIN_OUT,
        ST_DRAIN_EMPTY
    } state_t;

    state_t             state_reg;
    logic [7:0]         debounce_reg;
    logic [17:0]        levels_reg;
    logic [KCNT_W-1:0]  rd_idx_reg;
    logic               upd_vld_reg;
    logic [KEY_W-1:0]   upd_idx_reg;
    logic [NUM_KEYS-1:0] hold_vld_reg;
    logic [NUM_KEYS-1:0] down_reg;
    logic [FILL_W-1:0]  press_fill_reg;
    logic [FILL_W-1:0]  release_fill_reg;
    logic               drain_rel_reg;
    logic [FILL_W-1:0]  drain_cnt_reg;
    logic [FILL_W-1:0]  drain_idx_reg;
    logic               evt_valid_reg;
    evt_t               evt_reg;

    // Memories and their registered read data.
    logic [7:0]         hold_mem [NUM_KEYS];
    logic [5:0]         press_mem [QUEUE_DEPTH];
    logic [5:0]         release_mem [QUEUE_DEPTH];
    logic [7:0]         hold_q_reg;
    logic [5:0]         press_q_reg;
    logic [5:0]         release_q_reg;

    logic               req_acc;
    logic               out_free;
    logic               evt_load;
    logic               cfg_write;
    logic               rd_more;
    logic [KNUM_W-1:0]  upd_num;
    logic               level_hi;
    logic [7:0]         old_count;
    logic [7:0]         new_count;
    logic [7:0]         hold_wdata;
    logic               press_ev;
    logic               set_down;
    logic               release_ev;
    logic               press_we;
    logic               release_we;
    logic [5:0]         drained_key;

    assign req_stall = (state_reg != ST_IDLE);
    assign req_acc   = req_valid && !req_stall;
    assign out_free  = !evt_valid_reg || !evt_stall;
    assign evt_load  = out_free && ((state_reg == ST_DRAIN_OUT)
                                    || (state_reg == ST_DRAIN_EMPTY));
    assign cfg_write = psel && penable && pwrite;
    assign rd_more   = (rd_idx_reg < KCNT_W'(NUM_KEYS));

    assign evt_valid = evt_valid_reg;
    assign evt       = evt_reg;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == REG_DEBOUNCE) ? {24'b0, debounce_reg} : 32'b0;

    // Increment-and-compare unit shared by all keys of a scan.
    always_comb
    begin
        upd_num    = KNUM_W'(upd_idx_reg);
        level_hi   = (upd_num < KNUM_W'(LEVEL_BITS)) && levels_reg[upd_num[4:0]];
        old_count  = hold_vld_reg[upd_idx_reg] ? hold_q_reg : 8'd0;
        new_count  = (old_count != COUNT_MAX) ? old_count + 8'd1 : COUNT_MAX;
        hold_wdata = level_hi ? new_count : 8'd0;
        press_ev   = level_hi && (new_count == debounce_reg) && (new_count != old_count);
        set_down   = level_hi && (press_ev || (new_count > debounce_reg));
        release_ev = !level_hi && down_reg[upd_idx_reg];
        press_we   = upd_vld_reg && press_ev && (press_fill_reg < FILL_W'(QUEUE_DEPTH));
        release_we = upd_vld_reg && release_ev
                     && (release_fill_reg < FILL_W'(QUEUE_DEPTH));
        drained_key = drain_rel_reg ? release_q_reg : press_q_reg;
    end

    always_ff @(posedge clk)
    begin
        hold_q_reg <= hold_mem[rd_idx_reg[KEY_W-1:0]];
        if (upd_vld_reg)
        begin
            hold_mem[upd_idx_reg] <= hold_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        press_q_reg   <= press_mem[drain_idx_reg[QA_W-1:0]];
        release_q_reg <= release_mem[drain_idx_reg[QA_W-1:0]];
        if (press_we)
        begin
            press_mem[press_fill_reg[QA_W-1:0]] <= upd_num[5:0];
        end
        if (release_we)
        begin
            release_mem[release_fill_reg[QA_W-1:0]] <= upd_num[5:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            debounce_reg     <= DEBOUNCE_RESET;
            rd_idx_reg       <= '0;
            upd_vld_reg      <= 1'b0;
            upd_idx_reg      <= '0;
            hold_vld_reg     <= '0;
            down_reg         <= '0;
            press_fill_reg   <= '0;
            release_fill_reg <= '0;
            drain_rel_reg    <= 1'b0;
            drain_cnt_reg    <= '0;
            drain_idx_reg    <= '0;
            evt_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_write && (paddr[2] == REG_DEBOUNCE))
            begin
                debounce_reg <= pwdata[7:0];
            end

            if (evt_load)
            begin
                evt_valid_reg <= 1'b1;
            end
            else if (evt_valid_reg && !evt_stall)
            begin
                evt_valid_reg <= 1'b0;
            end

            // Write-back side of the scan pipeline.
            if (upd_vld_reg)
            begin
                hold_vld_reg[upd_idx_reg] <= 1'b1;
                if (set_down)
                begin
                    down_reg[upd_idx_reg] <= 1'b1;
                end
                else if (release_ev)
                begin
                    down_reg[upd_idx_reg] <= 1'b0;
                end
                if (press_we)
                begin
                    press_fill_reg <= press_fill_reg + FILL_W'(1);
                end
                if (release_we)
                begin
                    release_fill_reg <= release_fill_reg + FILL_W'(1);
                end
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (req_acc)
                    begin
                        drain_idx_reg <= '0;
                        rd_idx_reg    <= '0;
                        upd_vld_reg   <= 1'b0;
                        levels_reg    <= req.key_levels;
                        priority if (req.action == ACT_SCAN)
                        begin
                            state_reg <= ST_SCAN;
                        end
                        else if (req.action == ACT_DRAIN_PRESS)
                        begin
                            drain_rel_reg  <= 1'b0;
                            drain_cnt_reg  <= press_fill_reg;
                            press_fill_reg <= '0;
                            state_reg      <= (press_fill_reg == '0) ? ST_DRAIN_EMPTY
                                                                     : ST_DRAIN_RD;
                        end
                        else if (req.action == ACT_DRAIN_RELEASE)
                        begin
                            drain_rel_reg    <= 1'b1;
                            drain_cnt_reg    <= release_fill_reg;
                            release_fill_reg <= '0;
                            state_reg        <= (release_fill_reg == '0) ? ST_DRAIN_EMPTY
                                                                         : ST_DRAIN_RD;
                        end
                        else
                        begin
                            // The unused action is taken and dropped.
                            state_reg <= ST_IDLE;
                        end
                    end
                end

                ST_SCAN:
                begin
                    // Read of key rd_idx overlaps the write-back of key upd_idx.
                    if (rd_more)
                    begin
                        upd_vld_reg <= 1'b1;
                        upd_idx_reg <= rd_idx_reg[KEY_W-1:0];
                        rd_idx_reg  <= rd_idx_reg + KCNT_W'(1);
                    end
                    else
                    begin
                        upd_vld_reg <= 1'b0;
                        if (!upd_vld_reg)
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end

                ST_DRAIN_RD:
                begin
                    state_reg <= ST_DRAIN_OUT;
                end

                ST_DRAIN_OUT:
                begin
                    if (out_free)
                    begin
                        evt_reg.key_index            <= drained_key;
                        evt_reg.event_count          <= 5'(drain_cnt_reg);
                        evt_reg.queue_empty          <= 1'b0;
                        evt_reg.last                 <= (drain_idx_reg + FILL_W'(1)
                                                         == drain_cnt_reg);
                        evt_reg.presses_pending      <= 5'(press_fill_reg);
                        evt_reg.releases_pending     <= 5'(release_fill_reg);
                        drain_idx_reg                <= drain_idx_reg + FILL_W'(1);
                        state_reg <= (drain_idx_reg + FILL_W'(1) == drain_cnt_reg)
                                     ? ST_IDLE : ST_DRAIN_RD;
                    end
                end

                ST_DRAIN_EMPTY:
                begin
                    if (out_free)
                    begin
                        evt_reg.key_index        <= 6'd0;
                        evt_reg.event_count      <= 5'd0;
                        evt_reg.queue_empty      <= 1'b1;
                        evt_reg.last             <= 1'b1;
                        evt_reg.presses_pending  <= 5'(press_fill_reg);
                        evt_reg.releases_pending <= 5'(release_fill_reg);
                        state_reg                <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`include "assert_macros.svh"

    `ASSERT_IMPL(a_fill_bound, clk, rst_n, 1'b1,
        (press_fill_reg <= FILL_W'(QUEUE_DEPTH)) && (release_fill_reg <= FILL_W'(QUEUE_DEPTH)),
        "queue fill count exceeds the queue depth")
    `ASSERT_IMPL(a_empty_word, clk, rst_n, evt_valid && evt.queue_empty,
        evt.last && (evt.event_count == 5'd0), "empty-queue word is malformed")
    `ASSERT_IMPL(a_entry_word, clk, rst_n, evt_valid && !evt.queue_empty,
        evt.event_count != 5'd0, "drained entry word carries a zero count")
    `ASSERT_NEXT(a_busy_after_req, clk, rst_n,
        req_acc && ((req.action == ACT_SCAN) || (req.action == ACT_DRAIN_PRESS)
                    || (req.action == ACT_DRAIN_RELEASE)),
        state_reg != ST_IDLE, "accepted request did not start work")

endmodule

/* test/tb_key_matrix_debounce_event_queue_core.sv */
module tb_key_matrix_debounce_event_queue_core;
    timeunit 1ns;
    timeprecision 1ps;

    import kmdeq_pkg::*;

    localparam int KEYS = 18;
    localparam int QDEPTH = 16;
    localparam int RAND_PER_PHASE = 6;
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam logic [2:0] DEBOUNCE_ADDR = 3'(REG_DEBOUNCE) << 2;

    localparam evt_t NO_EVT = '0;
    localparam evt_t EMPTY_DRAIN = '{key_index: 6'd0, event_count: 5'd0, queue_empty: 1'b1,
                                     last: 1'b1, presses_pending: 5'd0,
                                     releases_pending: 5'd0};

    typedef struct packed {
        logic [1:0]  action;
        logic [17:0] levels;
        logic        typed;
        evt_t        want;
    } row_t;

    // Opening sequence at the reset debounce count of five.
    row_t directed_rows [0:21] = '{
        '{ACT_DRAIN_PRESS,   18'h00000, 1'b1, EMPTY_DRAIN},
        '{ACT_DRAIN_RELEASE, 18'h00000, 1'b1, EMPTY_DRAIN},
        '{ACT_UNUSED,        18'h3FFFF, 1'b0, NO_EVT},
        '{ACT_SCAN,          18'h3FFFF, 1'b0, NO_EVT},
        '{ACT_SCAN,          18'h3FFFF, 1'b0, NO_EVT},
        '{ACT_SCAN,          18'h3FFFF, 1'b0, NO_EVT},
        '{ACT_SCAN,          18'h3FFFF, 1'b0, NO_EVT},
        '{ACT_SCAN,          18'h3FFFF, 1'b0, NO_EVT},
        '{ACT_SCAN,          18'h3FFFF, 1'b0, NO_EVT},
        '{ACT_DRAIN_PRESS,   18'h3FFFF, 1'b0, NO_EVT},
        '{ACT_SCAN,          18'h00000, 1'b0, NO_EVT},
        '{ACT_DRAIN_RELEASE, 18'h00000, 1'b0, NO_EVT},
        '{ACT_DRAIN_RELEASE, 18'h15555, 1'b1, EMPTY_DRAIN},
        '{ACT_SCAN,          18'h2AAAA, 1'b0, NO_EVT},
        '{ACT_SCAN,          18'h2AAAA, 1'b0, NO_EVT},
        '{ACT_SCAN,          18'h2AAAA, 1'b0, NO_EVT},
        '{ACT_SCAN,          18'h2AAAA, 1'b0, NO_EVT},
        '{ACT_SCAN,          18'h2AAAA, 1'b0, NO_EVT},
        '{ACT_SCAN,          18'h15555, 1'b0, NO_EVT},
        '{ACT_DRAIN_PRESS,   18'h2AAAA, 1'b0, NO_EVT},
        '{ACT_DRAIN_RELEASE, 18'h15555, 1'b0, NO_EVT},
        '{ACT_SCAN,          18'h00000, 1'b0, NO_EVT}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    req_t        req = '0;
    logic        evt_valid;
    logic        evt_stall = 1'b0;
    evt_t        evt;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Predictor state.
    logic [7:0] debounce_now = DEBOUNCE_RESET;
    logic [7:0] hold_cnt [KEYS];
    bit         key_down [KEYS];
    logic [5:0] press_q [$];
    logic [5:0] release_q [$];

    evt_t        pending_events [$];
    int          mismatches = 0;
    bit          calm = 1'b0;
    int          rx_wait = 0;
    logic [17:0] levels_now = '0;
    int          flip_odds = 8;

    key_matrix_debounce_event_queue_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .evt_valid (evt_valid),
        .evt_stall (evt_stall),
        .evt       (evt),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #5 clk = ~clk;

    initial
    begin
        #10_000_000;
        $display("Some tests failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    function automatic int idle_draw();
        if (calm)
            return 0;
        return ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(0, 9));
    endfunction

    // Works out the event words one request word causes and updates the key state.
    function automatic void predict_events(input req_t w, output evt_t out[$]);
        logic [7:0] old_cnt;
        logic [7:0] new_cnt;
        logic [5:0] taken [$];
        evt_t       e;
        out = {};
        if (w.action == ACT_SCAN)
        begin
            for (int k = 0; k < KEYS; k++)
            begin
                if (w.key_levels[k])
                begin
                    old_cnt = hold_cnt[k];
                    new_cnt = (old_cnt < COUNT_MAX) ? old_cnt + 8'd1 : COUNT_MAX;
                    hold_cnt[k] = new_cnt;
                    if (new_cnt == debounce_now && new_cnt != old_cnt)
                    begin
                        key_down[k] = 1'b1;
                        if (press_q.size() < QDEPTH)
                            press_q.push_back(6'(k));
                    end
                    else if (new_cnt > debounce_now)
                    begin
                        // Already past the press point, e.g. the count was lowered mid-hold.
                        key_down[k] = 1'b1;
                    end
                end
                else
                begin
                    hold_cnt[k] = '0;
                    if (key_down[k])
                    begin
                        key_down[k] = 1'b0;
                        if (release_q.size() < QDEPTH)
                            release_q.push_back(6'(k));
                    end
                end
            end
        end
        else if (w.action == ACT_DRAIN_PRESS || w.action == ACT_DRAIN_RELEASE)
        begin
            if (w.action == ACT_DRAIN_PRESS)
            begin
                taken = press_q;
                press_q = {};
            end
            else
            begin
                taken = release_q;
                release_q = {};
            end
            e = '0;
            e.presses_pending = 5'(press_q.size());
            e.releases_pending = 5'(release_q.size());
            if (taken.size() == 0)
            begin
                e.queue_empty = 1'b1;
                e.last = 1'b1;
                out.push_back(e);
            end
            else
            begin
                for (int i = 0; i < taken.size(); i++)
                begin
                    e.key_index = taken[i];
                    e.event_count = 5'(taken.size());
                    e.last = (i == taken.size() - 1);
                    out.push_back(e);
                end
            end
        end
    endfunction

    // The caller lowers nothing after the accepting edge; the next call decides.
    task automatic send_word(input req_t w, input bit hold, input bit typed,
                             input evt_t want);
        int   gap;
        evt_t predicted [$];
        gap = idle_draw();
        if (hold && gap == 0)
            gap = 1;
        if (gap != 0)
            req_valid <= 1'b0;
        if (hold)
            while (pending_events.size() != 0)
                @(posedge clk);
        repeat (gap) @(posedge clk);
        req_valid <= 1'b1;
        req <= w;
        do
            @(posedge clk);
        while (req_stall);
        predict_events(w, predicted);
        if (typed)
            pending_events.push_back(want);
        else
            foreach (predicted[i])
                pending_events.push_back(predicted[i]);
    endtask

    // Must be called in the same step as the last acceptance.
    task automatic wait_quiet();
        req_valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        // A scan gives no word but keeps the block busy while it visits every key.
        repeat (KEYS + 6) @(posedge clk);
    endtask

    task automatic apb_access(input bit wr, input logic [2:0] addr,
                              input logic [31:0] data, output logic [31:0] rdata);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_debounce(input logic [7:0] value);
        logic [31:0] rd;
        apb_access(1'b1, DEBOUNCE_ADDR, 32'(value), rd);
        debounce_now = value;
        apb_access(1'b0, DEBOUNCE_ADDR, '0, rd);
        if (rd !== 32'(value))
            report_mismatch($sformatf("debounce readback %0h want %0h", rd, value));
    endtask

    function automatic req_t next_word();
        req_t w;
        int   pick;
        pick = $urandom_range(0, 99);
        w.key_levels = 18'($urandom);
        if (pick < 68)
        begin
            w.action = ACT_SCAN;
            if ($urandom_range(0, 24) == 0)
                levels_now = 18'($urandom);
            else if ($urandom_range(0, 39) == 0)
                levels_now = '1;
            else
                for (int b = 0; b < KEYS; b++)
                    if ($urandom_range(0, flip_odds - 1) == 0)
                        levels_now[b] = ~levels_now[b];
            w.key_levels = levels_now;
        end
        else if (pick < 80)
        begin
            w.action = ACT_DRAIN_PRESS;
        end
        else if (pick < 92)
        begin
            w.action = ACT_DRAIN_RELEASE;
        end
        else
        begin
            w.action = ACT_UNUSED;
        end
        return w;
    endfunction

    always @(posedge clk)
    begin : event_check
        evt_t want;
        if (rst_n && evt_valid && !evt_stall)
        begin
            if (pending_events.size() == 0)
            begin
                report_mismatch($sformatf("unexpected event word %h", evt));
            end
            else
            begin
                want = pending_events.pop_front();
                check_field("key_index", 8'(evt.key_index), 8'(want.key_index));
                check_field("event_count", 8'(evt.event_count), 8'(want.event_count));
                check_field("queue_empty", 8'(evt.queue_empty), 8'(want.queue_empty));
                check_field("last", 8'(evt.last), 8'(want.last));
                check_field("presses_pending", 8'(evt.presses_pending),
                            8'(want.presses_pending));
                check_field("releases_pending", 8'(evt.releases_pending),
                            8'(want.releases_pending));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            evt_stall <= 1'b0;
            rx_wait = 0;
        end
        else
        begin
            if (evt_valid && !evt_stall)
                rx_wait = idle_draw();
            else if (rx_wait != 0)
                rx_wait--;
            evt_stall <= (rx_wait != 0);
        end
    end

    initial
    begin
        logic [7:0]  phases [8];
        logic [31:0] rd;
        logic [17:0] held;
        req_t        w;

        phases = '{8'd1, 8'd255, 8'd3, 8'd0, 8'd2, 8'd8, 8'd6, 8'd1};
        foreach (hold_cnt[k])
        begin
            hold_cnt[k] = '0;
            key_down[k] = 1'b0;
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        apb_access(1'b0, DEBOUNCE_ADDR, '0, rd);
        if (rd !== 32'(DEBOUNCE_RESET))
            report_mismatch($sformatf("debounce after reset %0h", rd));

        foreach (directed_rows[i])
        begin
            w.action = directed_rows[i].action;
            w.key_levels = directed_rows[i].levels;
            send_word(w, 1'b0, directed_rows[i].typed, directed_rows[i].want);
        end
        wait_quiet();

        for (int ph = 0; ph < 8; ph++)
        begin
            set_debounce(phases[ph]);
            calm = (ph % 3 == 1);
            flip_odds = (phases[ph] > 12) ? 16 : phases[ph] + 4;
            if (phases[ph] == 8'd255)
            begin
                // Hold keys long enough to hit the press point and then saturate.
                held = 18'($urandom) | 18'h00001;
                w.key_levels = held;
                w.action = ACT_SCAN;
                repeat (258) send_word(w, 1'b0, 1'b0, NO_EVT);
                w.action = ACT_DRAIN_PRESS;
                send_word(w, 1'b0, 1'b0, NO_EVT);
                w.action = ACT_SCAN;
                w.key_levels = '0;
                send_word(w, 1'b0, 1'b0, NO_EVT);
                w.action = ACT_DRAIN_RELEASE;
                send_word(w, 1'b0, 1'b0, NO_EVT);
                // Leave these keys mid-hold so the lower count of the next phase
                // marks them down without a press.
                w.action = ACT_SCAN;
                w.key_levels = held;
                repeat (3) send_word(w, 1'b0, 1'b0, NO_EVT);
                levels_now = held;
            end
            for (int i = 0; i < RAND_PER_PHASE; i++)
            begin
                w = next_word();
                send_word(w, (ph == 0 && i == 3) || ($urandom_range(0, 29) == 0),
                          1'b0, NO_EVT);
            end
            wait_quiet();
        end

        calm = 1'b0;
        repeat (40) @(posedge clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* files.f */
+incdir+src
src/kmdeq_pkg.sv
src/key_matrix_debounce_event_queue_core.sv
test/tb_key_matrix_debounce_event_queue_core.sv
